// File: hw/rtl/assert_macros.svh
// Assertion macros used by the framer core RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must be true at every clock edge.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// Whenever the first expression is true, the second must be true in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/tsfr_pkg.sv
// Shared types, codes and frame tables for the TFT SPI framer.
// It has no dependencies, and every framer module imports it.
package tsfr_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [2:0] OP_CMD    = 3'd0;
    localparam logic [2:0] OP_DATA   = 3'd1;
    localparam logic [2:0] OP_WORD   = 3'd2;
    localparam logic [2:0] OP_WINDOW = 3'd3;
    localparam logic [2:0] OP_POINT  = 3'd4;

    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_PASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    typedef enum logic [2:0] {
        K_CMD    = 3'd0,
        K_DATA   = 3'd1,
        K_WORD   = 3'd2,
        K_WINDOW = 3'd3,
        K_POINT  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [15:0] xs;
        logic [15:0] xe;
        logic [15:0] ys;
        logic [15:0] ye;
    } t_desc;

    typedef struct packed {
        logic [7:0] b;
        logic       dc;
        logic       last;
    } t_frame;

    typedef struct packed {
        logic         full;
        logic         empty;
        logic [QAW:0] count;
    } t_q_status;

    function automatic logic [3:0] frame_count(t_kind k);
        logic [3:0] n;
        case (k)
            K_CMD:    n = 4'd1;
            K_DATA:   n = 4'd1;
            K_WORD:   n = 4'd2;
            K_WINDOW: n = 4'd10;
            K_POINT:  n = 4'd13;
            default:  n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic t_frame frame_of(t_desc d, logic [3:0] idx);
        t_frame f;
        f.dc   = 1'b1;
        f.b    = 8'h00;
        f.last = (idx == (frame_count(d.kind) - 4'd1));
        case (d.kind)
            K_CMD: begin
                f.dc = 1'b0;
                f.b  = d.value[7:0];
            end
            K_DATA: begin
                f.b = d.value[7:0];
            end
            K_WORD: begin
                f.b = (idx == 4'd0) ? d.value[15:8] : d.value[7:0];
            end
            default: begin
                case (idx)
                    4'd0: begin
                        f.dc = 1'b0;
                        f.b  = CMD_CASET;
                    end
                    4'd1:  f.b = d.xs[15:8];
                    4'd2:  f.b = d.xs[7:0];
                    4'd3:  f.b = d.xe[15:8];
                    4'd4:  f.b = d.xe[7:0];
                    4'd5: begin
                        f.dc = 1'b0;
                        f.b  = CMD_PASET;
                    end
                    4'd6:  f.b = d.ys[15:8];
                    4'd7:  f.b = d.ys[7:0];
                    4'd8:  f.b = d.ye[15:8];
                    4'd9:  f.b = d.ye[7:0];
                    4'd10: begin
                        f.dc = 1'b0;
                        f.b  = CMD_RAMWR;
                    end
                    4'd11: f.b = d.value[15:8];
                    default: f.b = d.value[7:0];
                endcase
            end
        endcase
        return f;
    endfunction

endpackage

// File: hw/rtl/tft_spi_pixel_command_framer_core.sv
// Turns display requests into the byte words of a serial TFT controller, one word per SPI frame,
// with the data/command level and a flag on the last word of each request. The back end sends
// one word per clock while the receiver keeps popping, and a request has one word for a
// command or data byte, two for a data word, ten for a window and thirteen for a point.
// The front end takes a new request every cycle while the four-entry request queue has room,
// and requests with an unknown op are taken and produce no words.
// Depends on tsfr_pkg, tsfr_front, tsfr_queue, tsfr_back and assert_macros.svh.
`include "assert_macros.svh"

module tft_spi_pixel_command_framer_core
    import tsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_value,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    output logic        empty,
    input  logic        pop,
    output logic        o_dc,
    output logic [7:0]  o_byte_out,
    output logic        o_last
);

    logic      f_valid;
    t_desc     f_desc;
    t_desc     q_head;
    t_q_status q_st;
    logic      q_pop;
    logic [3:0] b_idx;

    tsfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_op     (i_op),
        .i_value  (i_value),
        .i_x      (i_x),
        .i_y      (i_y),
        .i_width  (i_width),
        .i_height (i_height),
        .i_q_full (q_st.full),
        .o_valid  (f_valid),
        .o_desc   (f_desc)
    );

    tsfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid),
        .i_wdata  (f_desc),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_st)
    );

    tsfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q        (q_st),
        .o_q_pop    (q_pop),
        .o_idx      (b_idx),
        .empty      (empty),
        .pop        (pop),
        .o_dc       (o_dc),
        .o_byte_out (o_byte_out),
        .o_last     (o_last)
    );

    `ASSERT_ALWAYS(a_q_bound, q_st.count <= (QAW+1)'(QDEPTH))
    `ASSERT_IMPLIES(a_idx_range, !q_st.empty, b_idx < frame_count(q_head.kind))
    `ASSERT_IMPLIES(a_idle_idx, q_st.empty, b_idx == 4'd0)

endmodule

// File: hw/rtl/tsfr_front.sv
// Front end of the framer: accepts requests, classifies them and computes window ends.
// Depends on tsfr_pkg.
module tsfr_front
    import tsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_value,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    input  logic        i_q_full,
    output logic        o_valid,
    output t_desc       o_desc
);

    logic  r_valid, n_valid;
    t_desc r_desc, n_desc;
    logic  take, known, moved;

    always_comb begin
        take  = push && !full;
        moved = r_valid && !i_q_full;
        known = 1'b1;
        n_desc = r_desc;
        n_desc.value = i_value;
        n_desc.xs    = i_x;
        n_desc.ys    = i_y;
        n_desc.xe    = i_x + i_width;
        n_desc.ye    = i_y + i_height;
        case (i_op)
            OP_CMD:    n_desc.kind = K_CMD;
            OP_DATA:   n_desc.kind = K_DATA;
            OP_WORD:   n_desc.kind = K_WORD;
            OP_WINDOW: n_desc.kind = K_WINDOW;
            OP_POINT: begin
                n_desc.kind = K_POINT;
                n_desc.xe   = i_x + 16'd1;
                n_desc.ye   = i_y + 16'd1;
            end
            default: begin
                n_desc.kind = K_CMD;
                known       = 1'b0;
            end
        endcase
        if (take && known) begin
            n_valid = 1'b1;
        end else if (moved) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (take && known) begin
            r_desc <= n_desc;
        end
    end

    assign full    = r_valid && i_q_full;
    assign o_valid = r_valid;
    assign o_desc  = r_desc;

endmodule

// File: hw/rtl/tsfr_queue.sv
// Short queue of request descriptors between the front and back ends.
// Depends on tsfr_pkg.
module tsfr_queue
    import tsfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_desc     i_wdata,
    input  logic      i_pop,
    output t_desc     o_head,
    output t_q_status o_status
);

    t_desc          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           do_push, do_pop;

    always_comb begin
        do_push = i_push && (r_cnt != (QAW+1)'(QDEPTH));
        do_pop  = i_pop && (r_cnt != '0);
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt   = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_status.count = r_cnt;

endmodule

// File: hw/rtl/tsfr_back.sv
// Back end of the framer: steps through the frames of the head request into an output register.
// Depends on tsfr_pkg.
module tsfr_back
    import tsfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_head,
    input  t_q_status  i_q,
    output logic       o_q_pop,
    output logic [3:0] o_idx,
    output logic       empty,
    input  logic       pop,
    output logic       o_dc,
    output logic [7:0] o_byte_out,
    output logic       o_last
);

    logic       r_ov, n_ov;
    logic [3:0] r_idx, n_idx;
    t_frame     r_fr;
    t_frame     fr;
    logic       adv;

    always_comb begin
        fr      = frame_of(i_head, r_idx);
        adv     = !i_q.empty && (!r_ov || pop);
        o_q_pop = adv && fr.last;
        n_idx   = r_idx;
        if (adv) begin
            n_idx = fr.last ? 4'd0 : r_idx + 4'd1;
        end
        if (adv) begin
            n_ov = 1'b1;
        end else if (pop) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 4'd0;
        end else begin
            r_ov  <= n_ov;
            r_idx <= n_idx;
        end
        if (adv) begin
            r_fr <= fr;
        end
    end

    assign o_idx      = r_idx;
    assign empty      = !r_ov;
    assign o_dc       = r_fr.dc;
    assign o_byte_out = r_fr.b;
    assign o_last     = r_fr.last;

endmodule

// File: verif/tb_tft_spi_pixel_command_framer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for tft_spi_pixel_command_framer_core: requests go in through the queue
// port, and every SPI word that comes out is compared with a predicted word list.
// Depends on tsfr_pkg and the framer RTL only.

module tb_tft_spi_pixel_command_framer_core;
    import tsfr_pkg::*;

    localparam logic [2:0] OP_NONE_FIRST = 3'd5;
    localparam logic [2:0] OP_NONE_LAST  = 3'd7;
    localparam int RANDOM_REQUESTS = 130;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        bit       dc;
        bit [7:0] data;
        bit       last;
    } t_spi_word;

    class t_frame_scoreboard;
        t_spi_word expected_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function void add_word(bit dc, bit [7:0] data);
            t_spi_word w;
            w.dc   = dc;
            w.data = data;
            w.last = 1'b0;
            expected_q.push_back(w);
        endfunction

        function void add_data_word(logic [15:0] v);
            add_word(1'b1, v[15:8]);
            add_word(1'b1, v[7:0]);
        endfunction

        function void add_window(logic [15:0] xs, logic [15:0] xe,
                                 logic [15:0] ys, logic [15:0] ye);
            add_word(1'b0, CMD_CASET);
            add_data_word(xs);
            add_data_word(xe);
            add_word(1'b0, CMD_PASET);
            add_data_word(ys);
            add_data_word(ye);
        endfunction

        // Records the words that one accepted request must produce.
        function void note_request(logic [2:0] op, logic [15:0] value, logic [15:0] x,
                                   logic [15:0] y, logic [15:0] w, logic [15:0] h);
            int          first;
            logic [15:0] x_end;
            logic [15:0] y_end;
            first = expected_q.size();
            case (op)
                OP_CMD:    add_word(1'b0, value[7:0]);
                OP_DATA:   add_word(1'b1, value[7:0]);
                OP_WORD:   add_data_word(value);
                OP_WINDOW: begin
                    x_end = x + w;
                    y_end = y + h;
                    add_window(x, x_end, y, y_end);
                end
                OP_POINT: begin
                    x_end = x + 16'd1;
                    y_end = y + 16'd1;
                    add_window(x, x_end, y, y_end);
                    add_word(1'b0, CMD_RAMWR);
                    add_data_word(value);
                end
                default: ;
            endcase
            if (expected_q.size() > first) begin
                expected_q[expected_q.size() - 1].last = 1'b1;
            end
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic dc, logic [7:0] data, logic last);
            t_spi_word e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word dc=%b byte=%h last=%b", dc, data, last));
                return;
            end
            e = expected_q.pop_front();
            if (dc !== e.dc) begin
                report($sformatf("dc got %b want %b", dc, e.dc));
            end
            if (data !== e.data) begin
                report($sformatf("byte got %h want %h", data, e.data));
            end
            if (last !== e.last) begin
                report($sformatf("last got %b want %b", last, e.last));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_op = '0;
    logic [15:0] i_value = '0;
    logic [15:0] i_x = '0;
    logic [15:0] i_y = '0;
    logic [15:0] i_width = '0;
    logic [15:0] i_height = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_dc;
    logic [7:0]  o_byte_out;
    logic        o_last;

    t_frame_scoreboard sb = new();
    int  cycle_count = 0;
    bit  burst_mode = 1'b0;
    bit  hold_start = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  rx_stall = 0;

    tft_spi_pixel_command_framer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_x        (i_x),
        .i_y        (i_y),
        .i_width    (i_width),
        .i_height   (i_height),
        .empty      (empty),
        .pop        (pop),
        .o_dc       (o_dc),
        .o_byte_out (o_byte_out),
        .o_last     (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_tft_spi_pixel_command_framer_core NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Result side: checks every accepted word and decides pop for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                sb.check_word(o_dc, o_byte_out, o_last);
            end
            if (hold_start && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                pop       <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                pop      <= 1'b0;
            end else begin
                rx_stall <= burst_mode ? 0 : pick_gap();
                pop      <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [15:0] value,
                                input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] w, input logic [15:0] h);
        push     <= 1'b1;
        i_op     <= op;
        i_value  <= value;
        i_x      <= x;
        i_y      <= y;
        i_width  <= w;
        i_height <= h;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        sb.note_request(op, value, x, y, w, h);
    endtask

    task automatic sender_gap();
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_expected();
        while (sb.pending() != 0) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_field();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        if ($urandom_range(0, 99) < 6) begin
            return 3'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST));
        end
        return 3'($urandom_range(OP_CMD, OP_POINT));
    endfunction

    task automatic send_random(output bit counted);
        logic [2:0] op;
        op = pick_op();
        send_request(op, pick_field(), pick_field(), pick_field(), pick_field(), pick_field());
        counted = (op <= OP_POINT);
        sender_gap();
    endtask

    initial begin
        int  sent;
        bit  counted;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_CMD, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_CMD, 16'hABFF, 16'h1234, 16'h0, 16'h0, 16'h0);
        sender_gap();
        send_request(OP_DATA, 16'hFF00, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(OP_DATA, 16'h00FF, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0);
        send_request(OP_WORD, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(OP_WORD, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0);
        sender_gap();
        send_request(OP_WORD, 16'h1234, 16'h5555, 16'hAAAA, 16'h1, 16'h2);
        send_request(OP_WINDOW, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(OP_WINDOW, 16'h0, 16'hFFFF, 16'hFFF0, 16'h0001, 16'hFFFF);
        send_request(OP_WINDOW, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_WINDOW, 16'h0, 16'h00EF, 16'h013F, 16'h0010, 16'h0020);
        sender_gap();
        send_request(OP_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(OP_POINT, 16'hF81F, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(OP_POINT, 16'hFFFF, 16'h00FF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_POINT, 16'h07E0, 16'h1234, 16'h4321, 16'h00AA, 16'h5500);
        send_request(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(3'd6, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(OP_NONE_LAST, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(OP_CMD, 16'h0036, 16'h0, 16'h0, 16'h0, 16'h0);
        drain_expected();

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if (sent == 40) begin
                burst_mode <= 1'b1;
            end
            if (sent == 60) begin
                burst_mode <= 1'b0;
                hold_start <= 1'b1;
            end
            if (sent == 100) begin
                drain_expected();
            end
            send_random(counted);
            if (counted) begin
                sent++;
            end
        end
        push <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_tft_spi_pixel_command_framer_core OK");
        end else begin
            $display("tb_tft_spi_pixel_command_framer_core NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tsfr_pkg.sv
hw/rtl/tsfr_front.sv
hw/rtl/tsfr_queue.sv
hw/rtl/tsfr_back.sv
hw/rtl/tft_spi_pixel_command_framer_core.sv
verif/tb_tft_spi_pixel_command_framer_core.sv
